// File: sv/pgg_pkg.sv
package pgg_pkg;

    localparam int UNIFORM_BITS_DEF = 16;
    localparam int SCALE_W = 16;
    localparam int SAMPLE_W = 32;
    localparam int LOG_STEPS = 30;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS = 32;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
    localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

endpackage

// File: sv/polar_gaussian_generator_top.sv
// Normal sample generator using the polar method in fixed point.
// The input channel (i_valid, o_stall) carries a pair of uniform samples per
// transfer. A pair whose point falls outside the unit circle, or on its
// center, is dropped and produces nothing.
// Every kept pair produces two transfers on the output channel (o_valid,
// i_stall): the first coordinate's sample, then the second one with
// o_last_of_pair set. Samples are signed Q19.12.
// The work runs through a pipeline of 110 register stages: the
// logarithm by repeated squaring, two square roots and two divisions are
// each one stage per bit. The second sample of a pair is offered in the
// cycle after the first transfers. One output sample per cycle is sustained
// while i_stall stays low; a kept pair yields two, and the output register
// is the pacing point of the whole pipeline.
// When the receiver raises i_stall, the pipeline freezes and o_stall rises
// once the last stage holds a finished pair; nothing is lost or repeated.
// The scale register (unsigned Q8.8) is written through i_cfg_valid and
// i_cfg_data, always ready, and should be written only while idle.
// Synchronous reset clears all valid bits and sets the scale to 1.0.
module polar_gaussian_generator_top import pgg_pkg::*; #(
    parameter int UNIFORM_BITS = UNIFORM_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [UNIFORM_BITS-1:0]    i_uniform_a,
    input  logic [UNIFORM_BITS-1:0]    i_uniform_b,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_gaussian_sample,
    output logic                       o_last_of_pair,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [SCALE_W-1:0]         i_cfg_data
);

    localparam int MW = UNIFORM_BITS;
    localparam int FB = 2 * (UNIFORM_BITS - 1);
    localparam int FW = 2 + 2 * MW;
    localparam logic [MW-1:0] HALF = {1'b1, {(MW-1){1'b0}}};
    localparam logic [63:0] S_LIMIT = 64'd1 << FB;

    logic w_en;
    logic w_free;

    logic [SCALE_W-1:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_scale <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    logic          r_v1, r_na1, r_nb1;
    logic [MW-1:0] r_ma1, r_mb1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_na1 <= ~i_uniform_a[MW-1];
            r_nb1 <= ~i_uniform_b[MW-1];
            r_ma1 <= i_uniform_a[MW-1] ? i_uniform_a - HALF : HALF - i_uniform_a;
            r_mb1 <= i_uniform_b[MW-1] ? i_uniform_b - HALF : HALF - i_uniform_b;
        end
    end

    logic            r_v2;
    logic [2*MW-1:0] r_sqa2, r_sqb2;
    logic [FW-1:0]   r_f2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqa2 <= (2*MW)'(r_ma1) * (2*MW)'(r_ma1);
            r_sqb2 <= (2*MW)'(r_mb1) * (2*MW)'(r_mb1);
            r_f2   <= {r_na1, r_nb1, r_ma1, r_mb1};
        end
    end

    logic          r_v3;
    logic [63:0]   r_s3;
    logic [FW-1:0] r_f3;
    logic [63:0]   w_s;

    assign w_s = 64'(r_sqa2) + 64'(r_sqb2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2 && (w_s != 64'd0) && (w_s < S_LIMIT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3 <= w_s;
            r_f3 <= r_f2;
        end
    end

    logic          r_nv [6];
    logic [63:0]   r_nx [6];
    logic [5:0]    r_nz [6];
    logic [FW-1:0] r_nf [6];

    for (genvar k = 0; k < 6; k++) begin : g_norm
        localparam int SH = 32 >> k;
        logic          w_v;
        logic [63:0]   w_x;
        logic [5:0]    w_z;
        logic [FW-1:0] w_f;
        logic          w_top0;

        if (k == 0) begin : g_first
            assign w_v = r_v3;
            assign w_x = r_s3;
            assign w_z = '0;
            assign w_f = r_f3;
        end else begin : g_next
            assign w_v = r_nv[k-1];
            assign w_x = r_nx[k-1];
            assign w_z = r_nz[k-1];
            assign w_f = r_nf[k-1];
        end

        assign w_top0 = (w_x[63 -: SH] == '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nv[k] <= 1'b0;
            end else if (w_en) begin
                r_nv[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_nx[k] <= w_top0 ? (w_x << SH) : w_x;
                r_nz[k] <= w_top0 ? (w_z | 6'(SH)) : w_z;
                r_nf[k] <= w_f;
            end
        end
    end

    logic          r_v4;
    logic [31:0]   r_m4;
    logic [5:0]    r_p4, r_t4;
    logic [63:0]   r_sn4;
    logic [FW-1:0] r_f4;
    logic [5:0]    w_z;
    logic [5:0]    w_t;

    assign w_z = r_nz[5];
    assign w_t = (w_z <= 6'd3) ? 6'd0 : 6'((w_z - 6'd2) >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= r_nv[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m4  <= {1'b0, r_nx[5][63:33]};
            r_p4  <= 6'd63 - w_z;
            r_t4  <= w_t;
            r_sn4 <= r_nx[5] >> (w_z - {w_t[4:0], 1'b0});
            r_f4  <= r_nf[5];
        end
    end

    localparam int LSW = 6 + 6 + 64 + FW;
    logic           w_lv;
    logic [29:0]    w_frac;
    logic [LSW-1:0] w_lside;
    logic [5:0]     w_lp, w_lt;
    logic [63:0]    w_lsn;
    logic [FW-1:0]  w_lf;

    pgg_log2 #(.SIDE_W(LSW)) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_m     (r_m4),
        .i_side  ({r_p4, r_t4, r_sn4, r_f4}),
        .o_valid (w_lv),
        .o_frac  (w_frac),
        .o_side  (w_lside)
    );

    assign {w_lp, w_lt, w_lsn, w_lf} = w_lside;

    logic          r_v5;
    logic [36:0]   r_nl5;
    logic [5:0]    r_t5;
    logic [63:0]   r_sn5;
    logic [FW-1:0] r_f5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= w_lv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nl5 <= ((37'(FB) - 37'(w_lp)) << 30) - 37'(w_frac);
            r_t5  <= w_lt;
            r_sn5 <= w_lsn;
            r_f5  <= w_lf;
        end
    end

    logic          r_v6;
    logic [61:0]   r_pr6;
    logic [5:0]    r_t6;
    logic [63:0]   r_sn6;
    logic [FW-1:0] r_f6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
        end else if (w_en) begin
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pr6 <= 62'(r_nl5[36:6]) * 62'(TWO_LN2_Q30);
            r_t6  <= r_t5;
            r_sn6 <= r_sn5;
            r_f6  <= r_f5;
        end
    end

    logic          w_qv, w_rv;
    logic [31:0]   w_root, w_r;
    logic [FW-1:0] w_qf;
    logic [5:0]    w_rt;

    pgg_isqrt #(.SIDE_W(FW)) u_sqrt_log (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v6),
        .i_x     (64'(r_pr6[61:30]) << 24),
        .i_side  (r_f6),
        .o_valid (w_qv),
        .o_root  (w_root),
        .o_side  (w_qf)
    );

    pgg_isqrt #(.SIDE_W(6)) u_sqrt_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v6),
        .i_x     (r_sn6),
        .i_side  (r_t6),
        .o_valid (w_rv),
        .o_root  (w_r),
        .o_side  (w_rt)
    );

    logic          w_na, w_nb;
    logic [MW-1:0] w_ma, w_mb;
    logic [63:0]   w_numa, w_numb;

    assign {w_na, w_nb, w_ma, w_mb} = w_qf;
    assign w_numa = (64'(w_ma) << w_rt) << 30;
    assign w_numb = (64'(w_mb) << w_rt) << 30;

    logic        w_dav, w_dbv;
    logic [31:0] w_ca, w_cb;
    logic [32:0] w_das;
    logic        w_dbs;

    pgg_div #(.SIDE_W(33)) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_qv && w_rv),
        .i_num   (w_numa),
        .i_den   (w_r),
        .i_side  ({w_na, w_root}),
        .o_valid (w_dav),
        .o_quo   (w_ca),
        .o_side  (w_das)
    );

    pgg_div #(.SIDE_W(1)) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_qv && w_rv),
        .i_num   (w_numb),
        .i_den   (w_r),
        .i_side  (w_nb),
        .o_valid (w_dbv),
        .o_quo   (w_cb),
        .o_side  (w_dbs)
    );

    logic        r_v7, r_na7, r_nb7;
    logic [63:0] r_pa7, r_pb7;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v7 <= 1'b0;
        end else if (w_en) begin
            r_v7 <= w_dav && w_dbv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa7 <= 64'(w_ca) * 64'(w_das[31:0]);
            r_pb7 <= 64'(w_cb) * 64'(w_das[31:0]);
            r_na7 <= w_das[32];
            r_nb7 <= w_dbs;
        end
    end

    logic        r_v8, r_na8, r_nb8;
    logic [49:0] r_qa8, r_qb8;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v8 <= 1'b0;
        end else if (w_en) begin
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_qa8 <= 50'(r_pa7[63:30]) * 50'(r_scale);
            r_qb8 <= 50'(r_pb7[63:30]) * 50'(r_scale);
            r_na8 <= r_na7;
            r_nb8 <= r_nb7;
        end
    end

    logic                r_v9;
    logic [SAMPLE_W-1:0] r_ya9, r_yb9;
    logic [SAMPLE_W-1:0] w_maga, w_magb;

    assign w_maga = {2'b00, r_qa8[49:20]};
    assign w_magb = {2'b00, r_qb8[49:20]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v9 <= 1'b0;
        end else if (w_en) begin
            r_v9 <= r_v8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ya9 <= r_na8 ? (SAMPLE_W'(0) - w_maga) : w_maga;
            r_yb9 <= r_nb8 ? (SAMPLE_W'(0) - w_magb) : w_magb;
        end
    end

    logic                r_ov, r_olast;
    logic [SAMPLE_W-1:0] r_osamp, r_hold;

    assign w_free = !r_ov || (!i_stall && r_olast);
    assign w_en   = !r_v9 || w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_olast <= 1'b0;
        end else if (r_ov && !i_stall && !r_olast) begin
            r_olast <= 1'b1;
            r_osamp <= r_hold;
        end else if (w_free) begin
            r_ov    <= r_v9;
            r_olast <= 1'b0;
            r_osamp <= r_ya9;
            r_hold  <= r_yb9;
        end
    end

    assign o_stall           = !w_en;
    assign o_valid           = r_ov;
    assign o_gaussian_sample = r_osamp;
    assign o_last_of_pair    = r_olast;

`ifndef SYNTHESIS
    a_second_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_of_pair) |=> (o_valid && o_last_of_pair))
        else $error("Second sample of a pair did not follow the first.");

    a_kept_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r_s3 != 64'd0))
        else $error("A pair with zero radius was kept.");

    a_no_load_mid_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_of_pair) |-> !(r_v9 && w_en))
        else $error("The last stage advanced while a pair was half delivered.");
`endif

endmodule

// File: sv/pgg_log2.sv
module pgg_log2 import pgg_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [31:0]       i_m,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [29:0]       o_frac,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v [LOG_STEPS];
    logic [31:0]       r_m [LOG_STEPS];
    logic [29:0]       r_f [LOG_STEPS];
    logic [SIDE_W-1:0] r_s [LOG_STEPS];

    for (genvar g = 0; g < LOG_STEPS; g++) begin : g_step
        logic              w_v;
        logic [31:0]       w_m;
        logic [29:0]       w_f;
        logic [SIDE_W-1:0] w_s;
        logic [63:0]       w_sq;
        logic [31:0]       w_m2;
        logic [31:0]       n_m;
        logic [29:0]       n_f;

        if (g == 0) begin : g_first
            assign w_v = i_valid;
            assign w_m = i_m;
            assign w_f = '0;
            assign w_s = i_side;
        end else begin : g_next
            assign w_v = r_v[g-1];
            assign w_m = r_m[g-1];
            assign w_f = r_f[g-1];
            assign w_s = r_s[g-1];
        end

        assign w_sq = 64'(w_m) * 64'(w_m);
        assign w_m2 = w_sq[61:30];

        always_comb begin
            n_m = w_m2;
            n_f = w_f;
            if (w_m2[31]) begin
                n_m = w_m2 >> 1;
                n_f[LOG_STEPS-1-g] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[g] <= n_m;
                r_f[g] <= n_f;
                r_s[g] <= w_s;
            end
        end
    end

    assign o_valid = r_v[LOG_STEPS-1];
    assign o_frac  = r_f[LOG_STEPS-1];
    assign o_side  = r_s[LOG_STEPS-1];

endmodule

// File: sv/pgg_isqrt.sv
module pgg_isqrt import pgg_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [63:0]       i_x,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [31:0]       o_root,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v [SQRT_STEPS];
    logic [63:0]       r_x [SQRT_STEPS];
    logic [63:0]       r_r [SQRT_STEPS];
    logic [SIDE_W-1:0] r_s [SQRT_STEPS];

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
        logic              w_v;
        logic [63:0]       w_x;
        logic [63:0]       w_r;
        logic [SIDE_W-1:0] w_s;
        logic [63:0]       w_rb;
        logic [63:0]       n_x;
        logic [63:0]       n_r;

        if (g == 0) begin : g_first
            assign w_v = i_valid;
            assign w_x = i_x;
            assign w_r = '0;
            assign w_s = i_side;
        end else begin : g_next
            assign w_v = r_v[g-1];
            assign w_x = r_x[g-1];
            assign w_r = r_r[g-1];
            assign w_s = r_s[g-1];
        end

        assign w_rb = w_r + BIT;

        always_comb begin
            if (w_x >= w_rb) begin
                n_x = w_x - w_rb;
                n_r = (w_r >> 1) + BIT;
            end else begin
                n_x = w_x;
                n_r = w_r >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g] <= n_x;
                r_r[g] <= n_r;
                r_s[g] <= w_s;
            end
        end
    end

    assign o_valid = r_v[SQRT_STEPS-1];
    assign o_root  = r_r[SQRT_STEPS-1][31:0];
    assign o_side  = r_s[SQRT_STEPS-1];

endmodule

// File: sv/pgg_div.sv
module pgg_div import pgg_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [63:0]       i_num,
    input  logic [31:0]       i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [31:0]       o_quo,
    output logic [SIDE_W-1:0] o_side
);

    logic              r_v   [DIV_STEPS];
    logic [31:0]       r_rem [DIV_STEPS];
    logic [31:0]       r_lo  [DIV_STEPS];
    logic [31:0]       r_den [DIV_STEPS];
    logic [31:0]       r_q   [DIV_STEPS];
    logic [SIDE_W-1:0] r_s   [DIV_STEPS];

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic              w_v;
        logic [31:0]       w_rem;
        logic [31:0]       w_lo;
        logic [31:0]       w_den;
        logic [31:0]       w_q;
        logic [SIDE_W-1:0] w_s;
        logic [32:0]       w_rr;
        logic [31:0]       n_rem;
        logic [31:0]       n_q;

        if (g == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_rem = i_num[63:32];
            assign w_lo  = i_num[31:0];
            assign w_den = i_den;
            assign w_q   = '0;
            assign w_s   = i_side;
        end else begin : g_next
            assign w_v   = r_v[g-1];
            assign w_rem = r_rem[g-1];
            assign w_lo  = r_lo[g-1];
            assign w_den = r_den[g-1];
            assign w_q   = r_q[g-1];
            assign w_s   = r_s[g-1];
        end

        assign w_rr = {w_rem, w_lo[DIV_STEPS-1-g]};

        always_comb begin
            n_rem = w_rr[31:0];
            n_q   = w_q;
            if (w_rr >= {1'b0, w_den}) begin
                n_rem = 32'(w_rr - {1'b0, w_den});
                n_q[DIV_STEPS-1-g] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= n_rem;
                r_lo[g]  <= w_lo;
                r_den[g] <= w_den;
                r_q[g]   <= n_q;
                r_s[g]   <= w_s;
            end
        end
    end

    assign o_valid = r_v[DIV_STEPS-1];
    assign o_quo   = r_q[DIV_STEPS-1];
    assign o_side  = r_s[DIV_STEPS-1];

endmodule
